FILE: src/aie_pkg.sv
package aie_pkg;

    localparam logic [31:0] STACK_TOP_RESET = 32'h0010_0000;

    localparam logic [4:0] REG_STACK_A = 5'd30;
    localparam logic [4:0] REG_STACK_B = 5'd31;

    localparam logic [3:0] OPC_ALU = 4'd0;

    typedef enum logic [4:0] {
        TAG_ADD  = 5'd0,
        TAG_SUB  = 5'd1,
        TAG_SLL  = 5'd2,
        TAG_SRL  = 5'd3,
        TAG_SRA  = 5'd4,
        TAG_AND  = 5'd5,
        TAG_OR   = 5'd6,
        TAG_XOR  = 5'd7,
        TAG_UNE  = 5'd24,
        TAG_UEQ  = 5'd25,
        TAG_ULT  = 5'd26,
        TAG_ULE  = 5'd27,
        TAG_FNE  = 5'd28,
        TAG_FEQ  = 5'd29,
        TAG_FLT  = 5'd30,
        TAG_FLE  = 5'd31
    } t_tag;

    typedef struct packed {
        logic [3:0] opcode;
        logic [4:0] dest;
        logic [4:0] src_a;
        logic [4:0] src_b;
        logic [7:0] lit;
        logic [4:0] tag;
    } t_inst;

    typedef struct packed {
        logic        en;
        logic [4:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

endpackage

FILE: src/aie_regfile.sv
module aie_regfile
    import aie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [4:0]  i_rd_addr_a,
    input  logic [4:0]  i_rd_addr_b,
    input  t_rf_wr      i_wr,
    output logic [31:0] o_rd_a,
    output logic [31:0] o_rd_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_written;
    logic [31:0] r_data_a;
    logic [31:0] r_data_b;
    logic        r_ok_a;
    logic        r_ok_b;
    logic        r_byp_a;
    logic        r_byp_b;
    logic [31:0] r_fwd;
    logic [4:0]  r_addr_a;
    logic [4:0]  r_addr_b;

    function automatic logic [31:0] reset_value(input logic [4:0] addr);
        reset_value = (addr == REG_STACK_A || addr == REG_STACK_B) ? STACK_TOP_RESET : 32'd0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_data_a <= r_mem[i_rd_addr_a];
            r_data_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.en) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    // operand read in the same cycle as a write to that register takes the new value
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_ok_a   <= r_written[i_rd_addr_a];
            r_ok_b   <= r_written[i_rd_addr_b];
            r_byp_a  <= i_wr.en && (i_wr.addr == i_rd_addr_a);
            r_byp_b  <= i_wr.en && (i_wr.addr == i_rd_addr_b);
            r_fwd    <= i_wr.data;
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
    end

    assign o_rd_a = r_byp_a ? r_fwd : (r_ok_a ? r_data_a : reset_value(r_addr_a));
    assign o_rd_b = r_byp_b ? r_fwd : (r_ok_b ? r_data_b : reset_value(r_addr_b));

endmodule

FILE: src/aie_alu.sv
module aie_alu
    import aie_pkg::*;
(
    input  t_inst       i_inst,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_result,
    output logic        o_illegal
);

    logic [31:0] lit;
    logic [31:0] sum;
    logic [4:0]  sh;
    logic        nan;
    logic        both_zero;
    logic        f_eq;
    logic        f_lt;
    logic        mag_lt;
    logic        mag_gt;
    logic [31:0] res;
    logic        bad;

    assign lit       = {{24{i_inst.lit[7]}}, i_inst.lit};
    assign sum       = i_b + lit;
    assign sh        = sum[4:0];
    assign nan       = ((i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0))
                    || ((i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0));
    assign both_zero = ((i_a | i_b) & 32'h7FFF_FFFF) == 32'd0;
    assign mag_lt    = i_a < i_b;
    assign mag_gt    = i_a > i_b;
    assign f_eq      = both_zero || (i_a == i_b);

    always_comb begin
        if (both_zero) begin
            f_lt = 1'b0;
        end else if (i_a[31] != i_b[31]) begin
            f_lt = i_a[31];
        end else if (!i_a[31]) begin
            f_lt = mag_lt;
        end else begin
            f_lt = mag_gt;
        end
    end

    always_comb begin
        res = '0;
        bad = 1'b0;
        case (t_tag'(i_inst.tag))
            TAG_ADD: res = i_a + i_b + lit;
            TAG_SUB: res = i_a - i_b - lit;
            TAG_SLL: res = i_a << sh;
            TAG_SRL: res = i_a >> sh;
            TAG_SRA: res = $unsigned($signed(i_a) >>> sh);
            TAG_AND: res = i_a & i_b & lit;
            TAG_OR:  res = i_a | i_b | lit;
            TAG_XOR: res = i_a ^ i_b ^ lit;
            TAG_UNE: res = {31'd0, i_a != sum};
            TAG_UEQ: res = {31'd0, i_a == sum};
            TAG_ULT: res = {31'd0, i_a < sum};
            TAG_ULE: res = {31'd0, i_a <= sum};
            TAG_FNE: res = {31'd0, nan || !f_eq};
            TAG_FEQ: res = {31'd0, !nan && f_eq};
            TAG_FLT: res = {31'd0, !nan && f_lt};
            TAG_FLE: res = {31'd0, !nan && (f_lt || f_eq)};
            default: bad = 1'b1;
        endcase
        if (i_inst.opcode != OPC_ALU) begin
            bad = 1'b1;
        end
        if (bad) begin
            res = '0;
        end
    end

    assign o_result  = res;
    assign o_illegal = bad;

endmodule

FILE: src/alu_instruction_execute.sv
// ALU execute stage with a 32-entry register file.
// Input channel: i_in_valid / o_in_ready carry one 32-bit instruction word per
// transfer. Output channel: o_out_valid / i_out_ready carry dest index, the
// 32-bit result and the illegal flag, one result per instruction, in order.
// An accepted instruction is held first in the operand read registers and r_s1_inst,
// then in the output register, which loads together with the register file write-back.
// Throughput: one instruction per cycle while the output is not stalled; the
// register file forwards the previous instruction's result to the next read.
// Reset clears the pipeline; every register reads as zero except 30 and 31,
// which read as the stack top, until first written.
// When the receiver stalls, the result is held in the output register, one
// more instruction waits in the execute stage, and o_in_ready then drops.
// Illegal instructions report result 0 and write nothing.
module alu_instruction_execute
    import aie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_result_value,
    output logic        o_illegal
);

    logic        r_s1_valid;
    t_inst       r_s1_inst;
    logic        r_out_valid;
    logic [4:0]  r_dest;
    logic [31:0] r_result;
    logic        r_illegal;

    logic        n_s1_valid;
    logic        n_out_valid;
    logic        in_xfer;
    logic        advance;
    t_inst       in_inst;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] alu_result;
    logic        alu_illegal;
    t_rf_wr      wr;

    assign in_inst    = t_inst'(i_instruction);
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || advance;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign wr.en   = r_s1_valid && advance && !alu_illegal;
    assign wr.addr = r_s1_inst.dest;
    assign wr.data = alu_result;

    aie_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_xfer),
        .i_rd_addr_a (in_inst.src_a),
        .i_rd_addr_b (in_inst.src_b),
        .i_wr        (wr),
        .o_rd_a      (op_a),
        .o_rd_b      (op_b)
    );

    aie_alu u_alu (
        .i_inst    (r_s1_inst),
        .i_a       (op_a),
        .i_b       (op_b),
        .o_result  (alu_result),
        .o_illegal (alu_illegal)
    );

    always_comb begin
        n_s1_valid  = in_xfer ? 1'b1 : (advance ? 1'b0 : r_s1_valid);
        n_out_valid = advance ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_inst <= in_inst;
        end
        if (r_s1_valid && advance) begin
            r_dest    <= r_s1_inst.dest;
            r_result  <= alu_result;
            r_illegal <= alu_illegal;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_dest_index   = r_dest;
    assign o_result_value = r_result;
    assign o_illegal      = r_illegal;

endmodule

FILE: src/aie_checker.sv
module aie_checker
    import aie_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_instruction,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  o_dest_index,
    input logic [31:0] o_result_value,
    input logic        o_illegal
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_dest_index)
            && $stable(o_result_value) && $stable(o_illegal))
        else $error("stalled output transfer changed");

    a_illegal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_illegal |-> o_result_value == 32'd0)
        else $error("illegal instruction reported a nonzero result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

endmodule

bind alu_instruction_execute aie_checker u_aie_checker (.*);

FILE: test/aie_tb_pkg.sv
`timescale 1ns / 1ps

package aie_tb_pkg;
    import aie_pkg::*;

    typedef struct packed {
        logic [4:0]  dest;
        logic [31:0] value;
        logic        illegal;
    } t_writeback;

    class writeback_scoreboard;
        logic [31:0] reg_file [32];
        t_writeback  writeback_q [$];
        int          errors;

        function new();
            foreach (reg_file[i]) reg_file[i] = '0;
            reg_file[REG_STACK_A] = STACK_TOP_RESET;
            reg_file[REG_STACK_B] = STACK_TOP_RESET;
            errors = 0;
        endfunction

        function bit is_nan(logic [31:0] x);
            return (x[30:23] == 8'hFF) && (x[22:0] != '0);
        endfunction

        // both zeros compare equal regardless of sign
        function bit f_eq(logic [31:0] x, logic [31:0] y);
            return (((x | y) & 32'h7FFF_FFFF) == '0) || (x == y);
        endfunction

        function bit f_lt(logic [31:0] x, logic [31:0] y);
            if (((x | y) & 32'h7FFF_FFFF) == '0) return 1'b0;
            if (x[31] != y[31]) return x[31];
            if (!x[31]) return x < y;
            return x > y;
        endfunction

        // predict the writeback of one accepted instruction and update the register copy
        function void execute_instruction(logic [31:0] word);
            t_inst       f;
            logic [31:0] a, b, l, sum, r;
            logic [4:0]  sh;
            logic        bad, nan;
            f   = t_inst'(word);
            a   = reg_file[f.src_a];
            b   = reg_file[f.src_b];
            l   = {{24{f.lit[7]}}, f.lit};
            sum = b + l;
            sh  = sum[4:0];
            nan = is_nan(a) || is_nan(b);
            bad = 1'b0;
            r   = '0;
            if (f.opcode != OPC_ALU) begin
                bad = 1'b1;
            end else begin
                case (f.tag)
                    TAG_ADD: r = a + b + l;
                    TAG_SUB: r = a - b - l;
                    TAG_SLL: r = a << sh;
                    TAG_SRL: r = a >> sh;
                    TAG_SRA: r = (a >> sh) | (a[31] ? ~(32'hFFFF_FFFF >> sh) : 32'h0);
                    TAG_AND: r = a & b & l;
                    TAG_OR:  r = a | b | l;
                    TAG_XOR: r = a ^ b ^ l;
                    TAG_UNE: r = {31'b0, a != sum};
                    TAG_UEQ: r = {31'b0, a == sum};
                    TAG_ULT: r = {31'b0, a < sum};
                    TAG_ULE: r = {31'b0, a <= sum};
                    TAG_FNE: r = {31'b0, nan || !f_eq(a, b)};
                    TAG_FEQ: r = {31'b0, !nan && f_eq(a, b)};
                    TAG_FLT: r = {31'b0, !nan && f_lt(a, b)};
                    TAG_FLE: r = {31'b0, !nan && (f_lt(a, b) || f_eq(a, b))};
                    default: bad = 1'b1;
                endcase
            end
            if (bad) r = '0;
            else reg_file[f.dest] = r;
            writeback_q.push_back('{dest: f.dest, value: r, illegal: bad});
        endfunction

        function void check_writeback(logic [4:0] dest, logic [31:0] value, logic illegal);
            t_writeback e;
            if (writeback_q.size() == 0) begin
                $display("%0t unexpected result: dest %0d value %h illegal %b",
                         $time, dest, value, illegal);
                errors++;
                return;
            end
            e = writeback_q.pop_front();
            if (dest !== e.dest) begin
                $display("%0t dest_index mismatch: expected %0d, actual %0d",
                         $time, e.dest, dest);
                errors++;
            end
            if (value !== e.value) begin
                $display("%0t result_value mismatch: expected %h, actual %h",
                         $time, e.value, value);
                errors++;
            end
            if (illegal !== e.illegal) begin
                $display("%0t illegal mismatch: expected %b, actual %b",
                         $time, e.illegal, illegal);
                errors++;
            end
        endfunction

        function int outstanding();
            return writeback_q.size();
        endfunction
    endclass

endpackage

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import aie_pkg::*;
    import aie_tb_pkg::*;

    localparam int          RANDOM_ITEMS  = 650;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          HOLD_CYCLES   = 250;
    localparam int          DRAIN_CYCLES  = 10;
    localparam logic [3:0]  OPC_BAD       = 4'hF;
    localparam logic [4:0]  TAG_UNDEF_LO  = 5'd8;
    localparam logic [4:0]  TAG_UNDEF_HI  = 5'd23;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [31:0] instruction = '0;
    logic        out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [4:0]  o_dest_index;
    logic [31:0] o_result_value;
    logic        o_illegal;

    writeback_scoreboard wb_check;
    int  items_sent  = 0;
    int  idle_cycles = 0;
    bit  no_idle     = 1'b0;
    bit  hold_rx     = 1'b0;

    t_tag legal_tags [16] = '{TAG_ADD, TAG_SUB, TAG_SLL, TAG_SRL, TAG_SRA, TAG_AND,
                              TAG_OR, TAG_XOR, TAG_UNE, TAG_UEQ, TAG_ULT, TAG_ULE,
                              TAG_FNE, TAG_FEQ, TAG_FLT, TAG_FLE};

    alu_instruction_execute u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_instruction  (instruction),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_dest_index   (o_dest_index),
        .o_result_value (o_result_value),
        .o_illegal      (o_illegal)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] encode(logic [3:0] opc, logic [4:0] d, logic [4:0] a,
                                           logic [4:0] b, logic [7:0] lit, logic [4:0] tg);
        return {opc, d, a, b, lit, tg};
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    function automatic logic [31:0] pick_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = {v[31], 31'b0};
            1: v = {v[31], 8'hFF, 23'b0};
            2: v = {v[31], 8'hFF, v[22:1], 1'b1};
            3: v = {v[31], 8'h00, v[22:0]};
            4: v = {v[31], 6'b011111, v[24:23], v[22:0]};
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [31:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        instruction <= word;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        wb_check.execute_instruction(word);
        items_sent++;
    endtask

    // build a 32-bit value in d from a 4-bit head and four 7-bit chunks, t zeroed as scratch
    task automatic load_value(input logic [4:0] d, input logic [4:0] t, input logic [31:0] v);
        send_item(encode(OPC_ALU, t, t, t, 8'h00, TAG_XOR));
        send_item(encode(OPC_ALU, d, t, t, {4'b0, v[31:28]}, TAG_XOR));
        for (int k = 3; k >= 0; k--) begin
            send_item(encode(OPC_ALU, d, d, t, 8'd7, TAG_SLL));
            send_item(encode(OPC_ALU, d, d, t, {1'b0, v[k*7 +: 7]}, TAG_OR));
        end
    endtask

    task automatic send_random_op();
        logic [4:0] d, a, b, tg;
        logic [3:0] opc;
        logic [7:0] lit;
        int         pick;
        pick = $urandom_range(0, 99);
        d    = pick_reg();
        a    = pick_reg();
        b    = pick_reg();
        lit  = 8'($urandom);
        opc  = (pick >= 94) ? 4'($urandom_range(1, 15)) : OPC_ALU;
        tg   = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(TAG_UNDEF_LO, TAG_UNDEF_HI))
                                            : legal_tags[$urandom_range(0, 15)];
        if (pick < 20) begin
            b = a;
            case ($urandom_range(0, 2))
                0: lit = 8'hFF;
                1: lit = 8'h00;
                default: lit = 8'h01;
            endcase
        end
        if (pick < 8) send_item($urandom);
        else send_item(encode(opc, d, a, b, lit, tg));
    endtask

    // receiver
    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_rx) begin
                hold_rx = 1'b0;
                stall   = HOLD_CYCLES;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!o_out_valid) @(posedge clk);
            wb_check.check_writeback(o_dest_index, o_result_value, o_illegal);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int  next_phase;
        bit  hold_done;
        wb_check = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all operations, shift extremes, signed zero, NaN, illegal words
        send_item(encode(OPC_ALU, 5'd1, 5'd30, 5'd31, 8'hFF, TAG_ADD));
        send_item(encode(OPC_ALU, 5'd2, 5'd5, 5'd30, 8'h7F, TAG_SUB));
        send_item(encode(OPC_ALU, 5'd3, 5'd30, 5'd0, 8'd31, TAG_SLL));
        send_item(encode(OPC_ALU, 5'd3, 5'd1, 5'd31, 8'h00, TAG_SLL));
        send_item(encode(OPC_ALU, 5'd4, 5'd2, 5'd5, 8'hFF, TAG_SRL));
        send_item(encode(OPC_ALU, 5'd6, 5'd2, 5'd5, 8'd4, TAG_SRA));
        send_item(encode(OPC_ALU, 5'd6, 5'd2, 5'd5, 8'h00, TAG_SRA));
        send_item(encode(OPC_ALU, 5'd7, 5'd1, 5'd1, 8'h80, TAG_AND));
        send_item(encode(OPC_ALU, 5'd8, 5'd2, 5'd5, 8'h7F, TAG_OR));
        send_item(encode(OPC_ALU, 5'd9, 5'd2, 5'd1, 8'h80, TAG_XOR));
        send_item(encode(OPC_ALU, 5'd10, 5'd1, 5'd1, 8'h00, TAG_UNE));
        send_item(encode(OPC_ALU, 5'd10, 5'd1, 5'd1, 8'h00, TAG_UEQ));
        send_item(encode(OPC_ALU, 5'd11, 5'd5, 5'd2, 8'h7F, TAG_ULT));
        send_item(encode(OPC_ALU, 5'd11, 5'd2, 5'd5, 8'hFF, TAG_ULE));
        send_item(encode(OPC_ALU, 5'd12, 5'd12, 5'd12, 8'h80, TAG_XOR));
        send_item(encode(OPC_ALU, 5'd12, 5'd12, 5'd5, 8'd24, TAG_SLL));
        send_item(encode(OPC_ALU, 5'd13, 5'd12, 5'd5, 8'h00, TAG_FEQ));
        send_item(encode(OPC_ALU, 5'd13, 5'd12, 5'd5, 8'h00, TAG_FNE));
        send_item(encode(OPC_ALU, 5'd13, 5'd12, 5'd5, 8'h00, TAG_FLT));
        send_item(encode(OPC_ALU, 5'd13, 5'd12, 5'd5, 8'h00, TAG_FLE));
        send_item(encode(OPC_ALU, 5'd14, 5'd14, 5'd14, 8'hFF, TAG_XOR));
        send_item(encode(OPC_ALU, 5'd15, 5'd14, 5'd1, 8'h00, TAG_FNE));
        send_item(encode(OPC_ALU, 5'd15, 5'd1, 5'd14, 8'h00, TAG_FLE));
        send_item(encode(OPC_BAD, 5'd20, 5'd1, 5'd2, 8'h01, TAG_ADD));
        send_item(encode(OPC_ALU, 5'd21, 5'd1, 5'd2, 8'h01, TAG_UNDEF_LO));
        send_item(encode(OPC_ALU, 5'd22, 5'd1, 5'd2, 8'h01, TAG_UNDEF_HI));
        send_item(encode(OPC_ALU, 5'd0, 5'd0, 5'd0, 8'h01, TAG_ADD));

        // random: loaded float and integer patterns mixed with random operations
        next_phase = items_sent + 80;
        hold_done  = 1'b0;
        while (items_sent < RANDOM_ITEMS + 27) begin
            if (items_sent >= next_phase) begin
                no_idle    = ($urandom_range(0, 3) == 0);
                next_phase = items_sent + $urandom_range(40, 120);
            end
            if (!hold_done && items_sent >= 300) begin
                hold_done = 1'b1;
                no_idle   = 1'b1;
                hold_rx   = 1'b1;
            end
            if ($urandom_range(0, 9) < 3)
                load_value(5'($urandom_range(0, 7)), 5'($urandom_range(8, 15)),
                           ($urandom_range(0, 3) == 0) ? $urandom : pick_float());
            else
                send_random_op();
        end
        in_valid <= 1'b0;

        while (wb_check.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (wb_check.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
